@@ rtl/core/hpa_pkg.sv @@
// ============================================================================
// hpa_pkg
// Shared types and constants of the hash partition accumulator.
// ============================================================================
package hpa_pkg;

    localparam int PART_W  = 6;
    localparam int NPART   = 64;
    localparam int NKEYS   = 4;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
    localparam logic [1:0] CFG_WIDE_KEYS = 2'd1;
    localparam logic [1:0] CFG_PART_BITS = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [63:0] lead_key;
        logic [63:0] second_key;
        logic [63:0] third_key;
        logic [63:0] fourth_key;
        logic [63:0] row_value;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [PART_W-1:0] partition_index;
        logic [31:0]       slot_or_total;
        logic [63:0]       row_payload;
        logic              final_entry;
    } t_out;

    typedef struct packed {
        logic [2:0] key_count;
        logic       wide_keys;
        logic [2:0] partition_bits;
    } t_cfg;

    // Classified work handed from the hashing front to the counter back end.
    typedef struct packed {
        logic              mode;
        logic [PART_W-1:0] pid;
        logic [63:0]       payload;
    } t_task;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_ROW, B_SCAN, B_FOUT
    } t_bstate;

endpackage

@@ rtl/core/hash_partition_accumulator_unit.sv @@
// ============================================================================
// hash_partition_accumulator_unit
// Streaming radix partitioner: splitmix64 key hashing and partition fill counts.
// ============================================================================
// Each row item hashes its keys (key_count of them, saturated to four) with the
// splitmix64 finalizer, XORs the masked hashes into a partition index, and
// returns the row's slot taken from that partition's 32-bit saturating fill
// counter. A finalize item returns one total per non-empty partition in
// ascending order, the last one flagged, and clears every counter; with no
// rows placed it returns nothing. The front hashes on one shared 32x32
// multiplier, building both splitmix64 products of each key from 32-bit
// partial products, and takes no new item until the row is pushed. The back
// end takes a row from the queue, then writes out its slot; a finalize item
// it takes, then scans the partitions in order and reports each non-empty total.
// A two-entry queue lets the front hash the next row while the back end still
// waits on a stalled output. Configuration writes take effect at once; the user
// must make them only while the block is idle, as the block does not enforce it.
module hash_partition_accumulator_unit import hpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push, full, pop, empty;
    t_task f_task, q_task;

    // Register file: writes beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{key_count: 3'd1, wide_keys: 1'b1, partition_bits: 3'd6};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_COUNT: r_cfg.key_count      <= i_cfg_data;
                CFG_WIDE_KEYS: r_cfg.wide_keys      <= i_cfg_data[0];
                CFG_PART_BITS: r_cfg.partition_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_task  (f_task),
        .i_full  (full)
    );

    hpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (f_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_task  (q_task)
    );

    hpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_task  (q_task),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

@@ rtl/core/hpa_front.sv @@
// ============================================================================
// hpa_front
// Accepts items and hashes row keys into a partition index.
// ============================================================================
module hpa_front import hpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_data,
    input  t_cfg  i_cfg,
    output logic  o_push,
    output t_task o_task,
    input  logic  i_full
);

    localparam logic [2:0] S_M1_LO = 3'd0;
    localparam logic [2:0] S_M1_HA = 3'd1;
    localparam logic [2:0] S_M1_HB = 3'd2;
    localparam logic [2:0] S_M2_LO = 3'd3;
    localparam logic [2:0] S_M2_HA = 3'd4;
    localparam logic [2:0] S_M2_HB = 3'd5;
    localparam logic [2:0] S_FOLD  = 3'd6;

    t_fstate r_state, n_state;
    logic [63:0] r_keys [NKEYS];
    logic        r_mode;
    logic [63:0] r_value;
    logic [1:0]  r_kidx;
    logic [2:0]  r_step;
    logic [63:0] r_acc;
    logic [63:0] r_y;
    logic [PART_W-1:0] r_pid;

    logic [2:0]  kc_eff;
    logic [1:0]  kc_last;
    logic [2:0]  pb;
    logic [PART_W-1:0] mask;
    logic [63:0] xk, x, y;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [PART_W-1:0] h;
    logic        accept;

    always_comb begin
        kc_eff  = (i_cfg.key_count > 3'd4) ? 3'd4 : i_cfg.key_count;
        kc_last = 2'(kc_eff - 3'd1);
        pb      = i_cfg.partition_bits;
        mask    = (pb >= 3'd6) ? {PART_W{1'b1}} : ~({PART_W{1'b1}} << pb);
        xk      = i_cfg.wide_keys ? r_keys[r_kidx] : {32'd0, r_keys[r_kidx][31:0]};
        x       = xk ^ (xk >> 30);
        y       = r_acc ^ (r_acc >> 27);
        h       = r_acc[5:0] ^ r_acc[36:31];
        unique case (r_step)
            S_M1_LO: begin ma = x[31:0];    mb = MIX_C1[31:0];  end
            S_M1_HA: begin ma = x[31:0];    mb = MIX_C1[63:32]; end
            S_M1_HB: begin ma = x[63:32];   mb = MIX_C1[31:0];  end
            S_M2_LO: begin ma = y[31:0];    mb = MIX_C2[31:0];  end
            S_M2_HA: begin ma = r_y[31:0];  mb = MIX_C2[63:32]; end
            S_M2_HB: begin ma = r_y[63:32]; mb = MIX_C2[31:0];  end
            default: begin ma = '0;         mb = '0;            end
        endcase
        prod = 64'(ma) * 64'(mb);
    end

    assign accept  = i_valid && (r_state == F_IDLE);
    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_task  = '{mode: r_mode, pid: r_pid, payload: r_value};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_data.mode || kc_eff == 3'd0) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                if (r_step == S_FOLD && r_kidx == kc_last) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_keys[0] <= i_data.lead_key;
            r_keys[1] <= i_data.second_key;
            r_keys[2] <= i_data.third_key;
            r_keys[3] <= i_data.fourth_key;
            r_mode    <= i_data.mode;
            r_value   <= i_data.row_value;
            r_kidx    <= '0;
            r_step    <= S_M1_LO;
            r_pid     <= '0;
        end else if (r_state == F_HASH) begin
            unique case (r_step)
                S_M1_LO, S_M2_LO: r_acc <= prod;
                S_M1_HA, S_M1_HB, S_M2_HA, S_M2_HB: begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                end
                default: begin
                    r_pid <= r_pid ^ (h & mask);
                end
            endcase
            if (r_step == S_M2_LO) begin
                r_y <= y;
            end
            if (r_step == S_FOLD) begin
                r_step <= S_M1_LO;
                r_kidx <= r_kidx + 2'd1;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

endmodule

@@ rtl/core/hpa_queue.sv @@
// ============================================================================
// hpa_queue
// Two-entry queue of classified work between front and back.
// ============================================================================
module hpa_queue import hpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_task o_task
);

    t_task      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/core/hpa_back.sv @@
// ============================================================================
// hpa_back
// Fill counters, row slot assignment and the finalize scan.
// ============================================================================
module hpa_back import hpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_task i_task,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);

    t_bstate r_state, n_state;
    logic [31:0]       r_fill [NPART];
    logic [31:0]       r_rd;
    logic [NPART-1:0]  r_nz;
    logic [PART_W-1:0] r_p;
    logic [63:0]       r_payload;
    logic              r_ov;
    t_out              r_out;

    logic [PART_W-1:0] rd_addr;
    logic [31:0]       cnt;
    logic              out_free;
    logic              emit_row, emit_tot, last;

    assign out_free = !r_ov || !i_stall;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign rd_addr  = (r_state == B_IDLE) ? i_task.pid : r_p;
    assign cnt      = r_nz[r_p] ? r_rd : 32'd0;
    assign last     = ((r_nz >> r_p) >> 1) == '0;
    assign emit_row = (r_state == B_ROW) && out_free;
    assign emit_tot = (r_state == B_FOUT) && out_free;
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_task.mode ? B_SCAN : B_ROW;
                end
            end
            B_ROW: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            B_SCAN: begin
                if (r_nz[r_p]) begin
                    n_state = B_FOUT;
                end else if (r_p == PART_W'(NPART - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_FOUT: begin
                if (out_free) begin
                    n_state = (r_p == PART_W'(NPART - 1)) ? B_IDLE : B_SCAN;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_fill[rd_addr];
        if (emit_row) begin
            r_fill[r_p] <= (cnt == 32'hffffffff) ? cnt : cnt + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p       <= i_task.mode ? '0 : i_task.pid;
            r_payload <= i_task.payload;
        end else if ((r_state == B_SCAN && !r_nz[r_p]) || emit_tot) begin
            r_p <= r_p + PART_W'(1);
        end
        if (emit_row) begin
            r_out <= '{kind: 1'b0, partition_index: r_p, slot_or_total: cnt,
                       row_payload: r_payload, final_entry: 1'b1};
        end else if (emit_tot) begin
            r_out <= '{kind: 1'b1, partition_index: r_p, slot_or_total: cnt,
                       row_payload: 64'd0, final_entry: last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_nz    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_row) begin
                r_nz[r_p] <= 1'b1;
            end else if (emit_tot) begin
                r_nz[r_p] <= 1'b0;
            end
            if (emit_row || emit_tot) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/hpa_checker.sv @@
// ============================================================================
// hpa_checker
// Port-level checks of the hash partition accumulator.
// ============================================================================
module hpa_checker import hpa_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input t_out       o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_row_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.kind |-> o_data.final_entry)
        else $error("row placement not flagged final");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind |-> o_data.row_payload == 64'd0 &&
        o_data.slot_or_total != 32'd0)
        else $error("bad partition total");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken without going busy");

endmodule

bind hash_partition_accumulator_unit hpa_checker u_chk (.*);
